### hdl/lie_pkg.sv
// ----------------------------------------------------------------------------
// Lagrange evaluator package
// Shared types, default parameter values and code constants.
// ----------------------------------------------------------------------------
package lie_pkg;

  // Default sizing of the node table and fixed-point format.
  localparam int MaxNodesDef = 16;
  localparam int FracBitsDef = 16;

  // Symmetric limit of the wide intermediates.
  localparam logic [63:0] WideLim = 64'h7FFF_FFFF_FFFF_FFFF;

  // Item operation codes.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Result status codes.
  localparam logic [1:0] STATUS_OK  = 2'd0;
  localparam logic [1:0] STATUS_DUP = 2'd1;
  localparam logic [1:0] STATUS_SAT = 2'd2;

  // One input word as it travels through the queue.
  typedef struct packed {
    logic               op;
    logic [3:0]         node_index;
    logic signed [31:0] node_x;
    logic signed [31:0] node_y;
    logic signed [31:0] query_z;
  } item_t;

endpackage

### hdl/lie_if.sv
// ----------------------------------------------------------------------------
// Lagrange evaluator channels
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface lie_item_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic [3:0]         node_index;
  logic signed [31:0] node_x;
  logic signed [31:0] node_y;
  logic signed [31:0] query_z;

  modport source (output valid, op, node_index, node_x, node_y, query_z, input ready);
  modport sink   (input valid, op, node_index, node_x, node_y, query_z, output ready);
endinterface

interface lie_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic [1:0]         status;

  modport source (output valid, value, status, input ready);
  modport sink   (input valid, value, status, output ready);
endinterface

### hdl/lie_front.sv
// ----------------------------------------------------------------------------
// Lagrange evaluator front end
// Accepts input words, drops loads aimed past the table and queues the rest.
// ----------------------------------------------------------------------------
module lie_front #(
  parameter int MAX_NODES = lie_pkg::MaxNodesDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  lie_item_if.sink      item_i,
  output lie_pkg::item_t q_data_o,
  output logic          q_valid_o,
  input  logic          q_pop_i
);
  import lie_pkg::*;

  item_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       accept, keep, push;
  item_t      word;

  // Collect the payload into one word.
  always_comb begin
    word.op         = item_i.op;
    word.node_index = item_i.node_index;
    word.node_x     = item_i.node_x;
    word.node_y     = item_i.node_y;
    word.query_z    = item_i.query_z;
  end

  // Loads to a slot beyond the table are dropped here.
  assign item_i.ready = (cnt_q != 2'd2);
  assign accept       = item_i.valid & item_i.ready;
  assign keep         = (item_i.op == OP_QUERY) || (32'(item_i.node_index) < MAX_NODES);
  assign push         = accept & keep;

  assign q_valid_o = (cnt_q != 2'd0);
  assign q_data_o  = mem_q[rd_ptr_q];

  // Two-entry queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= word;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (q_pop_i) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end

endmodule

### hdl/lie_div.sv
// ----------------------------------------------------------------------------
// Lagrange evaluator divider
// Restoring divider, one quotient bit per cycle, of (num << FRAC) by den.
// ----------------------------------------------------------------------------
module lie_div #(
  parameter int FRAC_BITS = lie_pkg::FracBitsDef,
  localparam int NW = 33 + FRAC_BITS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [32:0]   num_i,
  input  logic [32:0]   den_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o
);
  localparam int CNW = $clog2(NW + 1);

  logic [NW-1:0]  dv_q, quo_q;
  logic [32:0]    den_q, rem_q;
  logic [CNW-1:0] cnt_q;
  logic           busy_q, done_q;
  logic [33:0]    trial;
  logic           ge;

  // One restoring step.
  assign trial = {rem_q, dv_q[NW-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        dv_q   <= {num_i, {FRAC_BITS{1'b0}}};
        den_q  <= den_i;
        rem_q  <= '0;
        cnt_q  <= CNW'(NW);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        dv_q  <= {dv_q[NW-2:0], 1'b0};
        rem_q <= ge ? 33'(trial - {1'b0, den_q}) : trial[32:0];
        quo_q <= {quo_q[NW-2:0], ge};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

### hdl/lie_mul.sv
// ----------------------------------------------------------------------------
// Lagrange evaluator multiplier
// Fixed-point product of two wide values from four 32x32 partial products,
// scaled down by FRAC bits and saturated symmetrically.
// ----------------------------------------------------------------------------
module lie_mul #(
  parameter int FRAC_BITS = lie_pkg::FracBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        done_o,
  output logic [63:0] res_o,
  output logic        sat_o
);
  import lie_pkg::*;

  logic [63:0]  ma_q, mb_q, pp_q;
  logic [127:0] acc_q, pp_wide;
  logic [1:0]   sh_q;
  logic [2:0]   k_q;
  logic         neg_q, pv_q, busy_q, done_q;
  logic [31:0]  aa, bb;
  logic [62:0]  m;

  // Operand halves for the current partial product.
  assign aa      = k_q[0] ? ma_q[63:32] : ma_q[31:0];
  assign bb      = k_q[1] ? mb_q[63:32] : mb_q[31:0];
  assign pp_wide = {64'b0, pp_q} << {sh_q, 5'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      pv_q   <= 1'b0;
      k_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        ma_q   <= a_i[63] ? 64'(-a_i) : a_i;
        mb_q   <= b_i[63] ? 64'(-b_i) : b_i;
        neg_q  <= a_i[63] ^ b_i[63];
        acc_q  <= '0;
        k_q    <= '0;
        pv_q   <= 1'b0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (pv_q) acc_q <= acc_q + pp_wide;
        if (k_q != 3'd4) begin
          pp_q <= 64'(aa) * 64'(bb);
          sh_q <= {1'b0, k_q[0]} + {1'b0, k_q[1]};
          pv_q <= 1'b1;
          k_q  <= k_q + 3'd1;
        end else begin
          pv_q <= 1'b0;
          if (!pv_q) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end
        end
      end
    end
  end

  // Scale, saturate and sign the accumulated product.
  assign sat_o  = |acc_q[127:FRAC_BITS+63];
  assign m      = sat_o ? WideLim[62:0] : acc_q[FRAC_BITS+62:FRAC_BITS];
  assign res_o  = neg_q ? 64'(-{1'b0, m}) : {1'b0, m};
  assign done_o = done_q;

endmodule

### hdl/lie_back.sv
// ----------------------------------------------------------------------------
// Lagrange evaluator back end
// Holds the node tables, writes loads into them and runs queries on a divider
// and a shared multiplier under a sequencer.
// ----------------------------------------------------------------------------
module lie_back #(
  parameter int MAX_NODES = lie_pkg::MaxNodesDef,
  parameter int FRAC_BITS = lie_pkg::FracBitsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           node_count_we_i,
  input  logic [4:0]     node_count_i,
  input  lie_pkg::item_t q_data_i,
  input  logic           q_valid_i,
  output logic           q_pop_o,
  lie_result_if.source   result_o
);
  import lie_pkg::*;

  localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int NW = 33 + FRAC_BITS;
  localparam logic [63:0] One = 64'(1) << FRAC_BITS;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DUP_RD, ST_DUP_CMP, ST_ROW, ST_COL, ST_RD, ST_DIV, ST_MUL,
    ST_YMUL, ST_FIN, ST_OUT
  } state_e;

  state_e             state_q;
  logic [4:0]         cnt_q;
  logic [CW-1:0]      n_q, i_q, j_q, n_sel;
  logic signed [31:0] x_mem [MAX_NODES];
  logic signed [31:0] y_mem [MAX_NODES];
  logic signed [31:0] xa_q, xb_q, ya_q, z_q;
  logic [63:0]        w_q, s_q;
  logic               sat_q, rneg_q;
  logic               ov_q;
  logic signed [31:0] ov_val_q, fin_val;
  logic [1:0]         ov_st_q;
  logic               mem_we;

  logic               div_start, div_done;
  logic [32:0]        num_d, den_d, num_m, den_m;
  logic [NW-1:0]      quo;
  logic [63:0]        ratio;
  logic               mul_start, mul_done, mul_sat;
  logic [63:0]        mul_b, mul_res;
  logic [64:0]        sum;
  logic [63:0]        sum_c;
  logic               sum_sat, fin_sat, out_free, ov_set;

  // Node count in use, capped at the table depth.
  assign n_sel = (32'(cnt_q) > MAX_NODES) ? CW'(MAX_NODES) : CW'(cnt_q);

  // Node table write and registered reads.
  assign mem_we = (state_q == ST_IDLE) && q_valid_i && (q_data_i.op == OP_LOAD);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      x_mem[IW'(q_data_i.node_index)] <= q_data_i.node_x;
      y_mem[IW'(q_data_i.node_index)] <= q_data_i.node_y;
    end
    xa_q <= x_mem[i_q[IW-1:0]];
    xb_q <= x_mem[j_q[IW-1:0]];
    ya_q <= y_mem[i_q[IW-1:0]];
  end

  // Differences for the ratio (z - x_j) / (x_i - x_j).
  assign num_d = {z_q[31], z_q} - {xb_q[31], xb_q};
  assign den_d = {xa_q[31], xa_q} - {xb_q[31], xb_q};
  assign num_m = num_d[32] ? 33'(-num_d) : num_d;
  assign den_m = den_d[32] ? 33'(-den_d) : den_d;
  assign div_start = (state_q == ST_RD);
  assign ratio = rneg_q ? 64'(-64'(quo)) : 64'(quo);

  lie_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i, .rst_ni,
    .start_i (div_start),
    .num_i   (num_m),
    .den_i   (den_m),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // Shared multiplier: weight times ratio, or weight times ordinate.
  assign mul_start = ((state_q == ST_DIV) && div_done) ||
                     ((state_q == ST_COL) && (j_q == n_q));
  assign mul_b = (state_q == ST_DIV) ? ratio : 64'(signed'(ya_q));

  lie_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk_i, .rst_ni,
    .start_i (mul_start),
    .a_i     (w_q),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .res_o   (mul_res),
    .sat_o   (mul_sat)
  );

  // Saturating accumulation of a term.
  assign sum = {s_q[63], s_q} + {mul_res[63], mul_res};
  always_comb begin
    sum_sat = 1'b0;
    sum_c   = sum[63:0];
    if (!sum[64] && sum[63]) begin
      sum_sat = 1'b1;
      sum_c   = WideLim;
    end else if (sum[64] && (sum[63:0] <= ~WideLim)) begin
      sum_sat = 1'b1;
      sum_c   = 64'(-WideLim);
    end
  end

  // Final clamp to 32 bits.
  always_comb begin
    fin_sat = 1'b1;
    if (!s_q[63] && (s_q[63:31] != '0)) begin
      fin_val = 32'sh7FFF_FFFF;
    end else if (s_q[63] && (s_q[63:31] != '1)) begin
      fin_val = 32'sh8000_0000;
    end else begin
      fin_val = s_q[31:0];
      fin_sat = 1'b0;
    end
  end

  assign q_pop_o  = (state_q == ST_IDLE) && q_valid_i;
  assign out_free = !ov_q || result_o.ready;

  // A new result word is loaded only once the previous one has been taken.
  assign ov_set = out_free && ((state_q == ST_FIN) || (state_q == ST_OUT));

  // Sequencer, configuration register and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= 5'd1;
      ov_q    <= 1'b0;
    end else begin
      if (node_count_we_i) cnt_q <= node_count_i;
      if (ov_set) begin
        ov_q <= 1'b1;
      end else if (result_o.ready) begin
        ov_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (q_valid_i && (q_data_i.op == OP_QUERY)) begin
            z_q   <= q_data_i.query_z;
            n_q   <= n_sel;
            i_q   <= '0;
            j_q   <= CW'(1);
            s_q   <= '0;
            sat_q <= 1'b0;
            if (n_sel == '0) begin
              state_q <= ST_FIN;
            end else if (n_sel == CW'(1)) begin
              state_q <= ST_ROW;
            end else begin
              state_q <= ST_DUP_RD;
            end
          end
        end
        ST_DUP_RD: begin
          state_q <= ST_DUP_CMP;
        end
        ST_DUP_CMP: begin
          if (xa_q == xb_q) begin
            s_q     <= '0;
            state_q <= ST_OUT;
          end else if (j_q + CW'(1) < n_q) begin
            j_q     <= j_q + CW'(1);
            state_q <= ST_DUP_RD;
          end else if (i_q + CW'(2) < n_q) begin
            i_q     <= i_q + CW'(1);
            j_q     <= i_q + CW'(2);
            state_q <= ST_DUP_RD;
          end else begin
            i_q     <= '0;
            state_q <= ST_ROW;
          end
        end
        ST_ROW: begin
          w_q     <= One;
          j_q     <= '0;
          state_q <= ST_COL;
        end
        ST_COL: begin
          if (j_q == n_q) begin
            state_q <= ST_YMUL;
          end else if (j_q == i_q) begin
            j_q <= j_q + CW'(1);
          end else begin
            state_q <= ST_RD;
          end
        end
        ST_RD: begin
          rneg_q  <= num_d[32] ^ den_d[32];
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) state_q <= ST_MUL;
        end
        ST_MUL: begin
          if (mul_done) begin
            w_q     <= mul_res;
            sat_q   <= sat_q | mul_sat;
            j_q     <= j_q + CW'(1);
            state_q <= ST_COL;
          end
        end
        ST_YMUL: begin
          if (mul_done) begin
            s_q   <= sum_c;
            sat_q <= sat_q | mul_sat | sum_sat;
            i_q   <= i_q + CW'(1);
            if (i_q + CW'(1) == n_q) begin
              state_q <= ST_FIN;
            end else begin
              state_q <= ST_ROW;
            end
          end
        end
        ST_FIN: begin
          if (out_free) begin
            ov_val_q <= fin_val;
            ov_st_q  <= (sat_q || fin_sat) ? STATUS_SAT : STATUS_OK;
            state_q  <= ST_IDLE;
          end
        end
        ST_OUT: begin
          // A duplicate abscissa reports a zero value.
          if (out_free) begin
            ov_val_q <= '0;
            ov_st_q  <= STATUS_DUP;
            state_q  <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign result_o.valid  = ov_q;
  assign result_o.value  = ov_val_q;
  assign result_o.status = ov_st_q;

endmodule

### hdl/lagrange_interpolation_eval_unit.sv
// A load is written into the node table from the queue; a query with n nodes
// runs a duplicate scan over all node pairs, then ratios and products for every
// term through the bit-serial divider and the four-step multiplier, and then
// the weighted ordinates are summed into the result.
// Queries run one at a time; a two-word queue keeps input open meanwhile.
// Reset: node_count returns to 1, queue and result empty; node tables undefined.
// ----------------------------------------------------------------------------
// Lagrange interpolation evaluator
// Top level: front end with word queue, back end with node tables and
// shared arithmetic.
// ----------------------------------------------------------------------------
module lagrange_interpolation_eval_unit #(
  parameter int MAX_NODES = lie_pkg::MaxNodesDef,
  parameter int FRAC_BITS = lie_pkg::FracBitsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         node_count_we_i,
  input  logic [4:0]   node_count_i,
  lie_item_if.sink     item_i,
  lie_result_if.source result_o
);
  import lie_pkg::*;

  item_t q_data;
  logic  q_valid, q_pop;

  // Front end and word queue.
  lie_front #(.MAX_NODES(MAX_NODES)) u_front (
    .clk_i, .rst_ni,
    .item_i    (item_i),
    .q_data_o  (q_data),
    .q_valid_o (q_valid),
    .q_pop_i   (q_pop)
  );

  // Back end.
  lie_back #(.MAX_NODES(MAX_NODES), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i, .rst_ni,
    .node_count_we_i,
    .node_count_i,
    .q_data_i  (q_data),
    .q_valid_i (q_valid),
    .q_pop_o   (q_pop),
    .result_o  (result_o)
  );

endmodule

### hdl/lie_checker.sv
// ----------------------------------------------------------------------------
// Lagrange evaluator port checker
// Watches the result channel of the top level over time.
// ----------------------------------------------------------------------------
module lie_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        res_valid,
  input logic        res_ready,
  input logic [31:0] res_value,
  input logic [1:0]  res_status
);
  import lie_pkg::*;

  // A stalled result word keeps its payload.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> $stable(res_value) && $stable(res_status))
    else $error("result word changed while stalled");

  // A result word stays offered until taken.
  a_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid)
    else $error("result word withdrawn");

  // Only defined status codes appear.
  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (res_status == STATUS_OK) || (res_status == STATUS_DUP) ||
                  (res_status == STATUS_SAT))
    else $error("undefined status code");

  // A duplicate abscissa always reports a zero value.
  a_dup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && (res_status == STATUS_DUP) |-> (res_value == '0))
    else $error("nonzero value with duplicate status");

endmodule

bind lagrange_interpolation_eval_unit lie_checker u_lie_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .res_valid  (result_o.valid),
  .res_ready  (result_o.ready),
  .res_value  (result_o.value),
  .res_status (result_o.status)
);
